[sv/dnp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnp_pkg: shared definitions for the decimal number parser
// Character codes, field widths and the result record passed from the
// accumulator to the output register.
// ----------------------------------------------------------------------------
package dnp_pkg;

	// default number of digits kept in the mantissa
	localparam int MAX_DIGITS_DEF = 8;

	// field widths
	localparam int CHAR_W    = 8;
	localparam int MANT_W    = 27;
	localparam int EXP_W     = 8;
	localparam int COUNT_W   = 8;
	localparam int DIGIT_W   = 4;
	localparam int M_TDATA_W = 48;  // negative, mantissa, exponent, length, zero fill

	// character codes
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

	// saturation limits
	localparam logic signed [EXP_W-1:0] EXP_MAX   = 8'sh7F;
	localparam logic signed [EXP_W-1:0] EXP_MIN   = 8'sh80;
	localparam logic [COUNT_W-1:0]      COUNT_MAX = 8'hFF;

	// one parsed number
	typedef struct packed {
		logic                    valid_res;
		logic                    negative;
		logic [MANT_W-1:0]       mantissa;
		logic signed [EXP_W-1:0] exponent;
		logic [COUNT_W-1:0]      consumed_length;
	} result_t;

endpackage

[sv/decimal_number_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_number_parser: character stream to decimal mantissa and exponent
// Parses an optional sign, digits and one point per number; emits one
// result on the terminating character.
// ----------------------------------------------------------------------------
// Channel  Dir  Contents
// s_*      in   s_tdata: char_in[7:0]; s_tuser: first
// m_*      out  m_tdata: negative, mantissa[26:0], exponent[7:0],
//                        consumed_length[7:0], zero fill; m_tuser: valid_res
//
// One character is accepted every cycle while s_tready is high. A character
// waits in the input register until the accumulator steps on it; a result
// shows on m_* the cycle after that. Reset clears the number state and both
// valid flags. When the result register is full and m_tready is low, the input
// register holds and s_tready drops once it is occupied.
// ----------------------------------------------------------------------------
module decimal_number_parser #(
	parameter int MAX_DIGITS = dnp_pkg::MAX_DIGITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [dnp_pkg::CHAR_W-1:0]    s_tdata,   // char_in
	input  logic                          s_tuser,   // first
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [dnp_pkg::M_TDATA_W-1:0] m_tdata,   // negative, mantissa, exponent,
	                                                 // consumed_length, zero fill
	output logic                          m_tuser    // valid_res
);

	logic                         valid_s1;
	logic                         first_s1;
	logic [dnp_pkg::CHAR_W-1:0]   char_s1;
	logic                         advance;
	logic                         emit;
	dnp_pkg::result_t             res;
	logic                         m_valid_q;
	dnp_pkg::result_t             res_q;

	// step when the result register can take a transaction
	assign advance  = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			first_s1 <= s_tuser;
			char_s1 <= s_tdata;
		end
	end

	dnp_accum #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_accum (
		.clk(clk),
		.arst_n(arst_n),
		.step_en(advance),
		.first(first_s1),
		.char_in(char_s1),
		.emit(emit),
		.res(res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance && emit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_q <= res;
		end
	end

	// drive the output channel
	assign m_tvalid = m_valid_q;
	assign m_tuser  = res_q.valid_res;
	assign m_tdata  = {4'b0000, res_q.consumed_length, res_q.exponent,
		res_q.mantissa, res_q.negative};

	// a failed parse carries an all-zero payload
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && !res_q.valid_res) |-> (m_tdata == '0))
		else $error("failed parse with nonzero payload");

	// exponent never drops below minus the kept digit count
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && res_q.valid_res) |->
		($signed(res_q.exponent) >= -MAX_DIGITS))
		else $error("exponent below kept digit range");

	// a character waiting in the input register is kept until stepped
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(char_s1) && $stable(first_s1)))
		else $error("pending character lost");

endmodule

[sv/dnp_accum.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnp_accum: per-character number accumulator
// Holds the state of the number in progress and advances it by one
// character when step_en is high; flags a result when a terminator arrives.
// ----------------------------------------------------------------------------
module dnp_accum #(
	parameter int MAX_DIGITS = dnp_pkg::MAX_DIGITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step_en,
	input  logic                        first,
	input  logic [dnp_pkg::CHAR_W-1:0]  char_in,
	output logic                        emit,
	output dnp_pkg::result_t            res
);

	// digit count saturates one above the kept digits
	localparam int DCW = $clog2(MAX_DIGITS + 2);
	localparam logic [DCW-1:0] DC_LIMIT = DCW'(MAX_DIGITS);

	logic                                busy_q, busy_d;
	logic                                minus_q, minus_d;
	logic                                point_q, point_d;
	logic [dnp_pkg::MANT_W-1:0]          acc_q, acc_d;
	logic [DCW-1:0]                      dc_q, dc_d;
	logic signed [dnp_pkg::EXP_W-1:0]    pow_q, pow_d;
	logic [dnp_pkg::COUNT_W-1:0]         cnt_q, cnt_d;

	logic                                is_digit, is_sign, is_point;
	logic [dnp_pkg::MANT_W-1:0]          digit_ext;
	logic [DCW-1:0]                      dc_inc;
	logic                                ok;

	// classify the character
	assign is_digit  = (char_in >= dnp_pkg::CHAR_ZERO) && (char_in <= dnp_pkg::CHAR_NINE);
	assign is_sign   = (char_in == dnp_pkg::CHAR_MINUS) || (char_in == dnp_pkg::CHAR_PLUS);
	assign is_point  = (char_in == dnp_pkg::CHAR_POINT);
	assign digit_ext = dnp_pkg::MANT_W'(char_in[dnp_pkg::DIGIT_W-1:0]);

	// next state and result for one character
	always_comb begin
		busy_d = busy_q;
		minus_d = minus_q;
		point_d = point_q;
		acc_d = acc_q;
		dc_d = dc_q;
		pow_d = pow_q;
		cnt_d = cnt_q;
		emit = 1'b0;
		ok = 1'b0;
		dc_inc = '0;
		res = '0;
		if (first) begin
			busy_d = 1'b1;
			minus_d = 1'b0;
			point_d = 1'b0;
			acc_d = '0;
			dc_d = '0;
			pow_d = '0;
			cnt_d = '0;
		end
		if (first && is_sign) begin
			// sign only on the opening character
			minus_d = (char_in == dnp_pkg::CHAR_MINUS);
			cnt_d = dnp_pkg::COUNT_W'(1);
		end else if (busy_d) begin
			if (is_digit) begin
				dc_inc = (dc_d <= DC_LIMIT) ? dc_d + DCW'(1) : dc_d;
				if (dc_inc <= DC_LIMIT) begin
					if (point_d && (pow_d != dnp_pkg::EXP_MIN)) begin
						pow_d = pow_d - 8'sd1;
					end
					acc_d = (acc_d << 3) + (acc_d << 1) + digit_ext;
				end else if (!point_d && (pow_d != dnp_pkg::EXP_MAX)) begin
					pow_d = pow_d + 8'sd1;
				end
				dc_d = dc_inc;
				if (cnt_d != dnp_pkg::COUNT_MAX) begin
					cnt_d = cnt_d + dnp_pkg::COUNT_W'(1);
				end
			end else if (is_point && !point_d) begin
				point_d = 1'b1;
				if (cnt_d != dnp_pkg::COUNT_MAX) begin
					cnt_d = cnt_d + dnp_pkg::COUNT_W'(1);
				end
			end else begin
				// terminator: report and drop the number
				emit = 1'b1;
				ok = (dc_d != '0);
				res.valid_res = ok;
				res.negative = ok && minus_d;
				res.mantissa = ok ? acc_d : '0;
				res.exponent = ok ? pow_d : '0;
				res.consumed_length = ok ? cnt_d : '0;
				busy_d = 1'b0;
				minus_d = 1'b0;
				point_d = 1'b0;
				acc_d = '0;
				dc_d = '0;
				pow_d = '0;
				cnt_d = '0;
			end
		end
	end

	// number state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			minus_q <= 1'b0;
			point_q <= 1'b0;
			acc_q <= '0;
			dc_q <= '0;
			pow_q <= '0;
			cnt_q <= '0;
		end else if (step_en) begin
			busy_q <= busy_d;
			minus_q <= minus_d;
			point_q <= point_d;
			acc_q <= acc_d;
			dc_q <= dc_d;
			pow_q <= pow_d;
			cnt_q <= cnt_d;
		end
	end

endmodule
